FILE: hdl/interval_heap_dual_priority_queue_core_macros.svh
// assertion helpers shared by the queue core
`ifndef INTERVAL_HEAP_DUAL_PRIORITY_QUEUE_CORE_MACROS_SVH
`define INTERVAL_HEAP_DUAL_PRIORITY_QUEUE_CORE_MACROS_SVH

// condition holds at every clock edge out of reset
`define IHDPQ_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define IHDPQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define IHDPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/ihdpq_pkg.sv
package ihdpq_pkg;

   // fixed field widths of the request and response
   localparam int DATA_WIDTH = 32;
   localparam int OP_WIDTH   = 2;
   localparam int ST_WIDTH   = 2;
   localparam int OCC_WIDTH  = 11;

   // operation codes
   localparam logic [OP_WIDTH-1:0] OP_PUSH    = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_POP_MIN = 2'd1;

   // response status codes
   localparam logic [ST_WIDTH-1:0] ST_PUSHED = 2'd0;
   localparam logic [ST_WIDTH-1:0] ST_POPPED = 2'd1;
   localparam logic [ST_WIDTH-1:0] ST_EMPTY  = 2'd2;
   localparam logic [ST_WIDTH-1:0] ST_FULL   = 2'd3;

   typedef struct packed {
      logic [OP_WIDTH-1:0]          op;
      logic signed [DATA_WIDTH-1:0] push_value;
   } req_item_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] popped_value;
      logic [ST_WIDTH-1:0]          status;
      logic [OCC_WIDTH-1:0]         occupancy;
   } rsp_item_type;

endpackage

FILE: hdl/ihdpq_ram.sv
module ihdpq_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/ihdpq_cmp.sv
module ihdpq_cmp #(
   parameter int WIDTH = 32
) (
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   output logic             lt
);

   // signed less-than on raw value patterns
   assign lt = $signed(a) < $signed(b);

endmodule

FILE: hdl/interval_heap_dual_priority_queue_core.sv
// Double-ended priority queue kept as an interval heap in one single-port-read memory.
// A request is taken when start is high and busy is low; busy then stays high until the
// response is out. The response appears on rsp_item for exactly one cycle with rsp_valid
// high and must be captured then, since the core cannot be stalled. A push climbs in each
// of the two heaps; a pop descends, and when the descent reaches a leaf it climbs as well.
// Each step of a sift up is one memory read, one signed compare in the shared comparator
// and one write; each step of a sift down reads both children and compares twice. A pop on
// an empty queue or a push on a full one changes nothing.
`include "interval_heap_dual_priority_queue_core_macros.svh"

module interval_heap_dual_priority_queue_core #(
   parameter int CAPACITY    = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ihdpq_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   output ihdpq_pkg::rsp_item_type rsp_item
);

   import ihdpq_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = AW + 2;
   localparam logic [AW-1:0] ONE_A = AW'(1);

   typedef enum logic [4:0] {
      S_IDLE,
      S_POP_RD_TOP,
      S_POP_RD_LAST,
      S_POP_LOAD,
      S_DN_ADDR,
      S_DN_RD_RC,
      S_DN_PICK,
      S_DN_SWAP,
      S_FLUSH_FIX,
      S_FIX_RD_L,
      S_FIX_RD_R,
      S_FIX_ORDER,
      S_UP_ADDR,
      S_UP_CMP,
      S_UP_RELOAD_RD,
      S_UP_RELOAD,
      S_DONE
   } state_type;

   typedef struct packed {
      logic          leaf;
      logic          rc_ok;
      logic [AW-1:0] lc;
      logic [AW-1:0] rc;
   } dn_addr_type;

   // child slots for a sift down from slot p
   function automatic dn_addr_type dn_addr(input logic [AW-1:0] p, input logic is_max,
                                           input logic [CW-1:0] n);
      logic [XW-1:0] lc;
      logic [XW-1:0] rc;
      logic [XW-1:0] nx;
      dn_addr_type   r;
      nx = XW'(n);
      if (is_max) begin
         lc = (XW'(p) << 1) | XW'(1);
         rc = lc + XW'(2);
         if (lc >= nx) lc = lc - XW'(1);
         if (rc >= nx) rc = rc - XW'(1);
      end else begin
         lc = (XW'(p) << 1) + XW'(2);
         rc = lc + XW'(2);
      end
      r.leaf  = lc >= nx;
      r.rc_ok = rc < nx;
      r.lc    = lc[AW-1:0];
      r.rc    = r.rc_ok ? rc[AW-1:0] : lc[AW-1:0];
      return r;
   endfunction

   // parent slot in the min heap, or in the max heap when is_max
   function automatic logic [AW-1:0] up_parent(input logic [AW-1:0] p, input logic is_max);
      logic [AW-1:0] t;
      t = p - AW'(2);
      return ((t >> 2) << 1) | AW'(is_max);
   endfunction

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [AW-1:0]    pos_ff, pos_in;
   logic [AW-1:0]    c_ff, c_in;
   logic [AW-1:0]    lc_ff, lc_in;
   logic [AW-1:0]    rc_ff, rc_in;
   logic [AW-1:0]    fix_ff, fix_in;
   logic             rc_ok_ff, rc_ok_in;
   logic             want_max_ff, want_max_in;
   logic             up_max_ff, up_max_in;
   logic             pair_ff, pair_in;
   logic [VALUE_WIDTH-1:0] cur_ff, cur_in;
   logic [VALUE_WIDTH-1:0] a_ff, a_in;
   logic [VALUE_WIDTH-1:0] hold_ff, hold_in;
   logic [VALUE_WIDTH-1:0] cval_ff, cval_in;
   logic [VALUE_WIDTH-1:0] popped_ff, popped_in;
   logic [ST_WIDTH-1:0]    status_ff, status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_ff, rsp_in;

   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   logic [VALUE_WIDTH-1:0] ram_wdata;
   logic [AW-1:0]          ram_raddr;
   logic [VALUE_WIDTH-1:0] ram_rdata;
   logic [VALUE_WIDTH-1:0] cmp_a;
   logic [VALUE_WIDTH-1:0] cmp_b;
   logic                   cmp_lt;

   dn_addr_type            da;
   logic [AW-1:0]          fix_l;
   logic [AW-1:0]          fix_r;
   logic                   fix_pair;
   logic                   pick_rc;
   logic                   up_end;

   ihdpq_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (VALUE_WIDTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ihdpq_cmp #(
      .WIDTH (VALUE_WIDTH)
   ) u_cmp (
      .a  (cmp_a),
      .b  (cmp_b),
      .lt (cmp_lt)
   );

   // slot arithmetic
   assign da       = dn_addr((state_ff == S_DN_SWAP) ? c_ff : pos_ff, want_max_ff, count_ff);
   assign fix_l    = fix_ff & ~ONE_A;
   assign fix_r    = fix_l | ONE_A;
   assign fix_pair = CW'(fix_r) < count_ff;
   assign pick_rc  = rc_ok_ff && cmp_lt;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      c_in         = c_ff;
      lc_in        = lc_ff;
      rc_in        = rc_ff;
      fix_in       = fix_ff;
      rc_ok_in     = rc_ok_ff;
      want_max_in  = want_max_ff;
      up_max_in    = up_max_ff;
      pair_in      = pair_ff;
      cur_in       = cur_ff;
      a_in         = a_ff;
      hold_in      = hold_ff;
      cval_in      = cval_ff;
      popped_in    = popped_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = pos_ff;
      ram_wdata    = cur_ff;
      ram_raddr    = '0;
      cmp_a        = '0;
      cmp_b        = '0;
      up_end       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               popped_in = '0;
               if (req_item.op == OP_PUSH) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     status_in = ST_PUSHED;
                     pos_in    = count_ff[AW-1:0];
                     cur_in    = VALUE_WIDTH'(req_item.push_value);
                     count_in  = count_ff + CW'(1);
                     state_in  = S_FLUSH_FIX;
                  end
               end else if (count_ff == '0) begin
                  status_in = ST_EMPTY;
                  state_in  = S_DONE;
               end else begin
                  status_in   = ST_POPPED;
                  want_max_in = req_item.op != OP_POP_MIN;
                  pos_in      = ((req_item.op != OP_POP_MIN) && (count_ff >= CW'(2))) ?
                                ONE_A : '0;
                  count_in    = count_ff - CW'(1);
                  state_in    = S_POP_RD_TOP;
               end
            end
         end

         // read the top slot, then the last one
         S_POP_RD_TOP: begin
            ram_raddr = pos_ff;
            state_in  = S_POP_RD_LAST;
         end
         S_POP_RD_LAST: begin
            ram_raddr = count_ff[AW-1:0];
            popped_in = ram_rdata;
            state_in  = S_POP_LOAD;
         end
         S_POP_LOAD: begin
            cur_in   = ram_rdata;
            state_in = (CW'(pos_ff) < count_ff) ? S_DN_ADDR : S_DONE;
         end

         // sift down: fetch children, pick one, compare with the moving value
         S_DN_ADDR: begin
            if (da.leaf) begin
               state_in = S_FLUSH_FIX;
            end else begin
               ram_raddr = da.lc;
               lc_in     = da.lc;
               rc_in     = da.rc;
               rc_ok_in  = da.rc_ok;
               state_in  = S_DN_RD_RC;
            end
         end
         S_DN_RD_RC: begin
            ram_raddr = rc_ff;
            a_in      = ram_rdata;
            state_in  = S_DN_PICK;
         end
         S_DN_PICK: begin
            cmp_a    = want_max_ff ? a_ff : ram_rdata;
            cmp_b    = want_max_ff ? ram_rdata : a_ff;
            c_in     = pick_rc ? rc_ff : lc_ff;
            cval_in  = pick_rc ? ram_rdata : a_ff;
            state_in = S_DN_SWAP;
         end
         S_DN_SWAP: begin
            cmp_a  = want_max_ff ? cur_ff : cval_ff;
            cmp_b  = want_max_ff ? cval_ff : cur_ff;
            ram_we = 1'b1;
            if (cmp_lt) begin
               ram_wdata = cval_ff;
               pos_in    = c_ff;
               if (da.leaf) begin
                  state_in = S_FLUSH_FIX;
               end else begin
                  ram_raddr = da.lc;
                  lc_in     = da.lc;
                  rc_in     = da.rc;
                  rc_ok_in  = da.rc_ok;
                  state_in  = S_DN_RD_RC;
               end
            end else begin
               state_in = S_DONE;
            end
         end

         // store the moving value, then order its slot pair
         S_FLUSH_FIX: begin
            ram_we   = 1'b1;
            fix_in   = pos_ff;
            state_in = S_FIX_RD_L;
         end
         S_FIX_RD_L: begin
            ram_raddr = fix_l;
            state_in  = S_FIX_RD_R;
         end
         S_FIX_RD_R: begin
            a_in    = ram_rdata;
            pair_in = fix_pair;
            if (fix_pair) begin
               ram_raddr = fix_r;
               state_in  = S_FIX_ORDER;
            end else begin
               cur_in    = ram_rdata;
               pos_in    = fix_l;
               up_max_in = 1'b0;
               state_in  = S_UP_ADDR;
            end
         end
         S_FIX_ORDER: begin
            cmp_a     = ram_rdata;
            cmp_b     = a_ff;
            cur_in    = cmp_lt ? ram_rdata : a_ff;
            hold_in   = cmp_lt ? a_ff : ram_rdata;
            pos_in    = fix_l;
            up_max_in = 1'b0;
            state_in  = S_UP_ADDR;
         end

         // sift up in the min heap, then in the max heap
         S_UP_ADDR: begin
            if (XW'(pos_ff) < XW'(2)) begin
               up_end = 1'b1;
            end else begin
               ram_raddr = up_parent(pos_ff, up_max_ff);
               c_in      = up_parent(pos_ff, up_max_ff);
               state_in  = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            cmp_a = up_max_ff ? ram_rdata : cur_ff;
            cmp_b = up_max_ff ? cur_ff : ram_rdata;
            if (cmp_lt) begin
               ram_we    = 1'b1;
               ram_wdata = ram_rdata;
               pos_in    = c_ff;
               state_in  = S_UP_ADDR;
            end else begin
               up_end = 1'b1;
            end
         end
         S_UP_RELOAD_RD: begin
            ram_raddr = fix_l;
            state_in  = S_UP_RELOAD;
         end
         S_UP_RELOAD: begin
            cur_in   = ram_rdata;
            pos_in   = fix_l;
            state_in = S_UP_ADDR;
         end

         S_DONE: begin
            rsp_valid_in        = 1'b1;
            rsp_in.popped_value = DATA_WIDTH'(popped_ff);
            rsp_in.status       = status_ff;
            rsp_in.occupancy    = OCC_WIDTH'(count_ff);
            state_in            = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // end of a sift up: store the value, start the max heap climb or finish
      if (up_end) begin
         ram_we = 1'b1;
         if (up_max_ff) begin
            state_in = S_DONE;
         end else begin
            up_max_in = 1'b1;
            if (pair_ff) begin
               cur_in   = hold_ff;
               pos_in   = fix_r;
               state_in = S_UP_ADDR;
            end else if (pos_ff == fix_l) begin
               state_in = S_UP_ADDR;
            end else begin
               state_in = S_UP_RELOAD_RD;
            end
         end
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      c_ff        <= c_in;
      lc_ff       <= lc_in;
      rc_ff       <= rc_in;
      fix_ff      <= fix_in;
      rc_ok_ff    <= rc_ok_in;
      want_max_ff <= want_max_in;
      up_max_ff   <= up_max_in;
      pair_ff     <= pair_in;
      cur_ff      <= cur_in;
      a_ff        <= a_in;
      hold_ff     <= hold_in;
      cval_ff     <= cval_in;
      popped_ff   <= popped_in;
      status_ff   <= status_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // checks
   `IHDPQ_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(CAPACITY), "count above capacity")
   `IHDPQ_ASSERT_IMPLY(a_write_inside, clock, reset, ram_we, CW'(ram_waddr) < count_ff, "write past last element")
   `IHDPQ_ASSERT_IMPLY(a_rsp_idle, clock, reset, rsp_valid, !busy, "response while busy")
   `IHDPQ_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "request taken but not busy")
   `IHDPQ_ASSERT_IMPLY(a_empty_occ, clock, reset, rsp_valid && (rsp_item.status == ST_EMPTY), rsp_item.occupancy == '0, "empty pop with nonzero occupancy")

endmodule
